FILE: rtl/core/trma_pkg.sv
// Shared types, constants and helpers for the range-ranked mean angle block.
package trma_pkg;

   // Field widths fixed by the interface.
   localparam int ANGLE_W     = 20;
   localparam int RANGE_W     = 16;
   localparam int START_W     = 18;
   localparam int STEP_W      = 14;
   localparam int COUNT_W     = 3;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 18;

   // Reset value of the upper range bound.
   localparam logic [RANGE_W-1:0] MAX_RANGE_RESET = 16'hFFFF;

   typedef logic signed [ANGLE_W-1:0] angle_type;
   typedef logic [RANGE_W-1:0]        range_type;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_START_ANGLE = 2'd0,
      CSR_ANGLE_STEP  = 2'd1,
      CSR_MIN_RANGE   = 2'd2,
      CSR_MAX_RANGE   = 2'd3
   } csr_index_type;

   // Configuration as seen by the datapath.
   typedef struct packed {
      logic signed [START_W-1:0] start_angle;
      logic signed [STEP_W-1:0]  angle_step;
      range_type                 min_range;
      range_type                 max_range;
   } cfg_type;

   // Clamp a one-bit-wider angle sum to the signed angle limits.
   function automatic angle_type sat_angle(input logic signed [ANGLE_W:0] value);
      angle_type result;
      if (value[ANGLE_W] != value[ANGLE_W-1]) begin
         result = value[ANGLE_W] ? {1'b1, {(ANGLE_W-1){1'b0}}}
                                 : {1'b0, {(ANGLE_W-1){1'b1}}};
      end else begin
         result = value[ANGLE_W-1:0];
      end
      return result;
   endfunction

endpackage

FILE: rtl/core/trma_slots.sv
// Ranked slot tracker: sample angle, range filter, sorted insertion and scan snapshot.
module trma_slots #(
   parameter int MAX_SAMPLES = 1024,
   parameter int TOP_COUNT   = 5
) (
   input  logic                      clock,
   input  logic                      reset,
   input  trma_pkg::cfg_type         cfg,
   input  logic                      item_valid,
   output logic                      item_ready,
   input  trma_pkg::range_type       item_range,
   input  logic                      item_finite,
   input  logic                      item_last,
   output logic                      snap_valid,
   input  logic                      snap_ready,
   output trma_pkg::angle_type       snap_angles [TOP_COUNT],
   output logic [TOP_COUNT-1:0]      snap_used
);

   localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
   localparam int ANGLE_W = trma_pkg::ANGLE_W;
   localparam int START_W = trma_pkg::START_W;
   localparam int STEP_W  = trma_pkg::STEP_W;

   logic [CNT_W-1:0]        count_ff, count_in;
   trma_pkg::angle_type     cur_angle_ff;
   trma_pkg::range_type     best_range_ff [TOP_COUNT];
   trma_pkg::angle_type     best_angle_ff [TOP_COUNT];
   logic [TOP_COUNT-1:0]    best_used_ff;
   logic                    snap_valid_ff;
   trma_pkg::angle_type     snap_angle_ff [TOP_COUNT];
   logic [TOP_COUNT-1:0]    snap_used_ff;

   // Slot contents one place further down, for the shift on insertion.
   trma_pkg::range_type     up_range [TOP_COUNT];
   trma_pkg::angle_type     up_angle [TOP_COUNT];
   logic [TOP_COUNT-1:0]    up_used;

   logic                    in_run;
   trma_pkg::angle_type     angle;
   logic signed [ANGLE_W:0] angle_next_wide;
   logic                    keep;
   logic [CNT_W-1:0]        count_run;
   logic                    produce;
   logic                    snap_free;
   logic                    consume;
   logic [TOP_COUNT-1:0]    outranks;
   trma_pkg::range_type     ins_range [TOP_COUNT];
   trma_pkg::angle_type     ins_angle [TOP_COUNT];
   logic [TOP_COUNT-1:0]    ins_used;

   for (genvar g = 0; g < TOP_COUNT; g++) begin : g_up
      if (g == 0) begin : g_first
         assign up_range[g] = best_range_ff[0];
         assign up_angle[g] = best_angle_ff[0];
         assign up_used[g]  = best_used_ff[0];
      end else begin : g_rest
         assign up_range[g] = best_range_ff[g-1];
         assign up_angle[g] = best_angle_ff[g-1];
         assign up_used[g]  = best_used_ff[g-1];
      end
   end

   // Angle of this sample, filter, and the next angle with saturation.
   always_comb begin
      in_run    = count_ff < CNT_W'(MAX_SAMPLES);
      angle     = (count_ff == '0)
                  ? {{(ANGLE_W-START_W){cfg.start_angle[START_W-1]}}, cfg.start_angle}
                  : cur_angle_ff;
      angle_next_wide = {angle[ANGLE_W-1], angle}
                  + {{(ANGLE_W+1-STEP_W){cfg.angle_step[STEP_W-1]}}, cfg.angle_step};
      keep      = in_run && item_finite && (item_range > cfg.min_range)
                  && (item_range < cfg.max_range);
      count_run = in_run ? count_ff + CNT_W'(1) : count_ff;
      produce   = item_last && (count_run >= CNT_W'(TOP_COUNT));
      snap_free = !snap_valid_ff || snap_ready;
      consume   = item_valid && (!produce || snap_free);
   end

   // Sorted insertion: the new sample lands at the first slot it outranks,
   // and every slot below it moves down by one.
   always_comb begin
      logic prev;
      prev = 1'b0;
      for (int i = 0; i < TOP_COUNT; i++) begin
         outranks[i] = !best_used_ff[i] || (item_range > best_range_ff[i])
                       || ((item_range == best_range_ff[i]) && (angle > best_angle_ff[i]));
         if (keep && outranks[i] && !prev) begin
            ins_range[i] = item_range;
            ins_angle[i] = angle;
            ins_used[i]  = 1'b1;
         end else if (keep && outranks[i]) begin
            ins_range[i] = up_range[i];
            ins_angle[i] = up_angle[i];
            ins_used[i]  = up_used[i];
         end else begin
            ins_range[i] = best_range_ff[i];
            ins_angle[i] = best_angle_ff[i];
            ins_used[i]  = best_used_ff[i];
         end
         prev = outranks[i];
      end
   end

   // Sample count: returns to zero at the end of every scan.
   always_comb begin
      count_in = count_ff;
      if (consume) begin
         count_in = item_last ? '0 : count_run;
      end
   end

   // Control state: count, slot occupancy and snapshot valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         best_used_ff  <= '0;
         snap_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (consume) begin
            best_used_ff <= item_last ? '0 : ins_used;
         end
         if (consume && produce) begin
            snap_valid_ff <= 1'b1;
         end else if (snap_ready) begin
            snap_valid_ff <= 1'b0;
         end
      end
   end

   // Slot payload, running angle and snapshot payload.
   always_ff @(posedge clock) begin
      if (consume) begin
         best_range_ff <= ins_range;
         best_angle_ff <= ins_angle;
         if (in_run) begin
            cur_angle_ff <= trma_pkg::sat_angle(angle_next_wide);
         end
      end
      if (consume && produce) begin
         snap_angle_ff <= ins_angle;
         snap_used_ff  <= ins_used;
      end
   end

   assign item_ready  = consume || !item_valid;
   assign snap_valid  = snap_valid_ff;
   assign snap_angles = snap_angle_ff;
   assign snap_used   = snap_used_ff;

endmodule

FILE: rtl/core/trma_mean.sv
// Held angle sum divided by TOP_COUNT: sum, magnitude, reciprocal multiply and result register.
module trma_mean #(
   parameter int TOP_COUNT = 5
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      snap_valid,
   output logic                      snap_ready,
   input  trma_pkg::angle_type       snap_angles [TOP_COUNT],
   input  logic [TOP_COUNT-1:0]      snap_used,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output trma_pkg::angle_type       rsp_mean_angle,
   output logic [trma_pkg::COUNT_W-1:0] rsp_kept_count
);

   localparam int ANGLE_W  = trma_pkg::ANGLE_W;
   localparam int COUNT_W  = trma_pkg::COUNT_W;
   localparam int LOG_T    = $clog2(TOP_COUNT);
   localparam int SUM_W    = ANGLE_W + LOG_T;
   localparam int MAG_W    = SUM_W;
   localparam int RECIP_W  = MAG_W + 1;
   localparam int PROD_W   = MAG_W + RECIP_W;
   localparam int SHIFT    = MAG_W + LOG_T;
   localparam int QUOT_W   = PROD_W - SHIFT;
   localparam int KC_W     = $clog2(TOP_COUNT + 1);
   // Rounded-up reciprocal; exact floor division for every MAG_W-bit magnitude.
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << SHIFT) + 64'(TOP_COUNT) - 64'd1) / 64'(TOP_COUNT));

   logic                     sum_valid_ff, mag_valid_ff, prod_valid_ff, rsp_valid_ff;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic [KC_W-1:0]          kept_sum_ff, kept_mag_ff, kept_prod_ff, kept_rsp_ff, kept_in;
   logic [MAG_W-1:0]         mag_ff, mag_in;
   logic                     neg_mag_ff, neg_prod_ff;
   logic [PROD_W-1:0]        prod_ff, prod_in;
   logic [QUOT_W-1:0]        quot;
   logic [QUOT_W-1:0]        quot_signed;
   trma_pkg::angle_type      mean_ff;

   logic rsp_free, prod_go, prod_free, mag_go, mag_free, sum_go, sum_free;

   // Stage advance: a stage moves when the next one is empty or moving.
   always_comb begin
      rsp_free  = !rsp_valid_ff || rsp_ready;
      prod_go   = prod_valid_ff && rsp_free;
      prod_free = !prod_valid_ff || prod_go;
      mag_go    = mag_valid_ff && prod_free;
      mag_free  = !mag_valid_ff || mag_go;
      sum_go    = sum_valid_ff && mag_free;
      sum_free  = !sum_valid_ff || sum_go;
   end

   // Sum of the held angles and their count.
   always_comb begin
      sum_in  = '0;
      kept_in = '0;
      for (int i = 0; i < TOP_COUNT; i++) begin
         if (snap_used[i]) begin
            sum_in  = sum_in + SUM_W'(snap_angles[i]);
            kept_in = kept_in + KC_W'(1);
         end
      end
   end

   // Magnitude, product and signed quotient.
   always_comb begin
      mag_in      = sum_ff[SUM_W-1] ? MAG_W'(-sum_ff) : MAG_W'(sum_ff);
      prod_in     = {{RECIP_W{1'b0}}, mag_ff} * {{MAG_W{1'b0}}, RECIP};
      quot        = prod_ff[PROD_W-1:SHIFT];
      quot_signed = neg_prod_ff ? (~quot + QUOT_W'(1)) : quot;
   end

   // Stage valids.
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff  <= 1'b0;
         mag_valid_ff  <= 1'b0;
         prod_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (sum_free) begin
            sum_valid_ff <= snap_valid;
         end
         if (mag_free) begin
            mag_valid_ff <= sum_valid_ff;
         end
         if (prod_free) begin
            prod_valid_ff <= mag_valid_ff;
         end
         if (rsp_free) begin
            rsp_valid_ff <= prod_valid_ff;
         end
      end
   end

   // Stage payloads.
   always_ff @(posedge clock) begin
      if (sum_free && snap_valid) begin
         sum_ff      <= sum_in;
         kept_sum_ff <= kept_in;
      end
      if (sum_go) begin
         mag_ff      <= mag_in;
         neg_mag_ff  <= sum_ff[SUM_W-1];
         kept_mag_ff <= kept_sum_ff;
      end
      if (mag_go) begin
         prod_ff      <= prod_in;
         neg_prod_ff  <= neg_mag_ff;
         kept_prod_ff <= kept_mag_ff;
      end
      if (prod_go) begin
         mean_ff     <= quot_signed[ANGLE_W-1:0];
         kept_rsp_ff <= kept_prod_ff;
      end
   end

   assign snap_ready     = sum_free;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_mean_angle = mean_ff;
   assign rsp_kept_count = COUNT_W'(kept_rsp_ff);

endmodule

FILE: rtl/core/top_range_mean_angle_top.sv
// Top level: configuration registers, input register and the two datapath parts.
// A result appears on rsp_valid after the last sample of its scan has passed the
// input, snapshot, sum, magnitude, product and result registers; other samples
// give no result. Sorted insertion into the ranked slots takes one sample per cycle
// unless a scan's last sample waits on the snapshot register; up to four finished results buffer in the mean pipeline.
// Reset (synchronous, active high) empties all slots and pipeline stages and
// loads the configuration reset values; it needs no clearing pass.
module top_range_mean_angle_top #(
   parameter int MAX_SAMPLES = 1024,
   parameter int TOP_COUNT   = 5
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [trma_pkg::RANGE_W-1:0]          req_range_mm,
   input  logic                                  req_range_finite,
   input  logic                                  req_last_sample,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [trma_pkg::ANGLE_W-1:0]   rsp_mean_angle,
   output logic [trma_pkg::COUNT_W-1:0]          rsp_kept_count,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [trma_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [trma_pkg::CSR_DATA_W-1:0]       csr_data
);

   localparam int START_W = trma_pkg::START_W;
   localparam int STEP_W  = trma_pkg::STEP_W;
   localparam int RANGE_W = trma_pkg::RANGE_W;

   trma_pkg::cfg_type    cfg_ff;
   logic                 item_valid_ff;
   trma_pkg::range_type  item_range_ff;
   logic                 item_finite_ff;
   logic                 item_last_ff;
   logic                 item_ready;
   logic                 snap_valid;
   logic                 snap_ready;
   trma_pkg::angle_type  snap_angles [TOP_COUNT];
   logic [TOP_COUNT-1:0] snap_used;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_angle <= '0;
         cfg_ff.angle_step  <= '0;
         cfg_ff.min_range   <= '0;
         cfg_ff.max_range   <= trma_pkg::MAX_RANGE_RESET;
      end else if (csr_valid) begin
         unique case (trma_pkg::csr_index_type'(csr_index))
            trma_pkg::CSR_START_ANGLE: cfg_ff.start_angle <= csr_data[START_W-1:0];
            trma_pkg::CSR_ANGLE_STEP:  cfg_ff.angle_step  <= csr_data[STEP_W-1:0];
            trma_pkg::CSR_MIN_RANGE:   cfg_ff.min_range   <= csr_data[RANGE_W-1:0];
            trma_pkg::CSR_MAX_RANGE:   cfg_ff.max_range   <= csr_data[RANGE_W-1:0];
            default: ;
         endcase
      end
   end

   // Input register: refills on the same cycle the held sample moves on.
   assign req_ready = !item_valid_ff || item_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_ready) begin
         item_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         item_range_ff  <= req_range_mm;
         item_finite_ff <= req_range_finite;
         item_last_ff   <= req_last_sample;
      end
   end

   trma_slots #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .TOP_COUNT   (TOP_COUNT)
   ) u_slots (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .item_valid  (item_valid_ff),
      .item_ready  (item_ready),
      .item_range  (item_range_ff),
      .item_finite (item_finite_ff),
      .item_last   (item_last_ff),
      .snap_valid  (snap_valid),
      .snap_ready  (snap_ready),
      .snap_angles (snap_angles),
      .snap_used   (snap_used)
   );

   trma_mean #(
      .TOP_COUNT (TOP_COUNT)
   ) u_mean (
      .clock          (clock),
      .reset          (reset),
      .snap_valid     (snap_valid),
      .snap_ready     (snap_ready),
      .snap_angles    (snap_angles),
      .snap_used      (snap_used),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_mean_angle (rsp_mean_angle),
      .rsp_kept_count (rsp_kept_count)
   );

endmodule
